// ===== src/spq_pkg.sv =====
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int PRIO_LEVELS  = 8;

    localparam int OP_W     = 2;
    localparam int HANDLE_W = 8;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(PRIO_LEVELS - 1);

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t ent;
    } cell_cmd_t;

endpackage

// ===== src/spq_cell.sv =====
module spq_cell (
    input  logic              aclk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic              occupied,
    input  logic              left_keep,
    input  spq_pkg::entry_t   left_ent,
    input  spq_pkg::entry_t   right_ent,
    output spq_pkg::entry_t   ent,
    output logic              keep
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // sorted chain: held entries of equal or higher priority stay put
    assign keep = occupied && (entry_reg.prio >= cmd.ent.prio);
    assign ent  = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.push && !keep) begin
            entry_next = left_keep ? cmd.ent : left_ent;
        end else if (cmd.pop) begin
            entry_next = right_ent;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== src/stable_priority_ready_queue_core.sv =====
// Channel  Dir  Fields (lsb first)
// s_axis   in   opcode[1:0], thread_handle[9:2], thread_priority[12:10]
// m_axis   out  front_handle[7:0], front_priority[10:8], status[12:11],
//               occupancy[12+CNT_W:13]
//
// Every operation works on the whole cell row in parallel (shift or insert):
// one item per cycle sustained while no result is held back by a low m_tready.
// Result appears in the cycle after its transfer, from a one-deep output register.
// s_tready drops only while a result waits and m_tready is low.
// aresetn (synchronous) empties the queue; cell contents are not cleared.
module stable_priority_ready_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // opcode, thread_handle, thread_priority
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((13 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
    // front_handle, front_priority, status, occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int M_W   = ((13 + CNT_W + 7) / 8) * 8;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    logic [M_W-1:0]   m_data_reg, m_data_next;

    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] in_handle;
    logic [PRIO_W-1:0]   in_prio;
    logic                fire, full, empty;
    cell_cmd_t           cmd;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [PRIO_W-1:0]   out_prio;

    entry_t cell_ent  [CAPACITY];
    logic   cell_keep [CAPACITY];

    assign op        = s_tdata[1:0];
    assign in_handle = s_tdata[9:2];
    assign in_prio   = s_tdata[12:10];

    assign s_tready = !m_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign empty    = count_reg == '0;

    always_comb begin
        cmd.push       = fire && (op == OP_PUSH) && !full;
        cmd.pop        = fire && (op == OP_POP) && !empty;
        cmd.ent.handle = in_handle;
        cmd.ent.prio   = (in_prio > PRIO_MAX) ? PRIO_MAX : in_prio;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   left_keep;
        entry_t left_ent;
        entry_t right_ent;
        if (i == 0) begin : g_first
            assign left_keep = 1'b1;
            assign left_ent  = cmd.ent;
        end else begin : g_mid
            assign left_keep = cell_keep[i-1];
            assign left_ent  = cell_ent[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_ent = cell_ent[i];
        end else begin : g_body
            assign right_ent = cell_ent[i+1];
        end
        spq_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .occupied  (count_reg > CNT_W'(i)),
            .left_keep (left_keep),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .ent       (cell_ent[i]),
            .keep      (cell_keep[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        status     = ST_OK;
        out_handle = '0;
        out_prio   = '0;
        case (op)
            OP_PUSH: begin
                if (full) begin
                    status = ST_FULL;
                end
            end
            OP_POP: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    out_handle = cell_ent[0].handle;
                    out_prio   = cell_ent[0].prio;
                end
            end
            OP_PEEK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    out_prio = cell_ent[0].prio;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        m_data_next = M_W'({count_next, status, out_prio, out_handle});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the queue");

    a_occ_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_data_reg[13 +: CNT_W] == count_reg)
        else $error("reported occupancy differs from count");

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push && cmd.pop))
        else $error("push and pop together");

endmodule

// ===== tb/stable_priority_ready_queue_core_test.sv =====
// Result word layout (lsb first): front_handle[7:0], front_priority[10:8],
// status[12:11], occupancy[17:13], zero fill up to 24 bits.
class ready_queue_scoreboard;
    spq_pkg::entry_t held_entries[$];
    logic [23:0]     pending_results[$];
    int              errors;

    function new();
        errors = 0;
    endfunction

    // Runs one accepted request against the queue copy and queues its result.
    function void note_request(logic [15:0] d);
        logic [1:0]      op;
        logic [7:0]      hnd;
        logic [2:0]      pri;
        logic [7:0]      fh;
        logic [2:0]      fp;
        logic [1:0]      st;
        spq_pkg::entry_t ent;
        int              pos;
        op  = d[1:0];
        hnd = d[9:2];
        pri = d[12:10];
        fh  = '0;
        fp  = '0;
        st  = spq_pkg::ST_OK;
        case (op)
            spq_pkg::OP_PUSH: begin
                if (held_entries.size() >= spq_pkg::CAPACITY_DEF) begin
                    st = spq_pkg::ST_FULL;
                end else begin
                    if (int'(pri) >= spq_pkg::PRIO_LEVELS)
                        pri = spq_pkg::PRIO_MAX;
                    // goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].prio >= pri)
                        pos++;
                    ent.handle = hnd;
                    ent.prio   = pri;
                    held_entries.insert(pos, ent);
                end
            end
            spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
                if (held_entries.size() == 0) begin
                    st = spq_pkg::ST_EMPTY;
                end else begin
                    fp = held_entries[0].prio;
                    if (op == spq_pkg::OP_POP) begin
                        fh = held_entries[0].handle;
                        void'(held_entries.pop_front());
                    end
                end
            end
            default: ;
        endcase
        pending_results.push_back({6'b0, 5'(held_entries.size()), st, fp, fh});
    endfunction

    function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
            errors++;
        end
    endfunction

    function void check_response(logic [23:0] r);
        logic [23:0] exp_word;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none got %h", $time, r);
            errors++;
            return;
        end
        exp_word = pending_results.pop_front();
        compare_field("front_handle", exp_word[7:0], r[7:0]);
        compare_field("front_priority", {5'b0, exp_word[10:8]}, {5'b0, r[10:8]});
        compare_field("status", {6'b0, exp_word[12:11]}, {6'b0, r[12:11]});
        compare_field("occupancy", {3'b0, exp_word[17:13]}, {3'b0, r[17:13]});
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction
endclass

module stable_priority_ready_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int idle_pct  = 36;
    bit press_req = 1'b0;

    ready_queue_scoreboard sb = new();

    stable_priority_ready_queue_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("** stable_priority_ready_queue_core: FAILED **");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_response(m_tdata);
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (press_req) begin
                press_req = 1'b0;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
            @(posedge aclk);
        end
    end

    function automatic logic [15:0] pack_request(logic [1:0] op, logic [7:0] hnd,
                                                 logic [2:0] pri);
        return {3'b0, pri, hnd, op};
    endfunction

    task automatic send_request(logic [15:0] d);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    initial begin : stimulus
        int          n;
        int          push_pct;
        int          r;
        logic [1:0]  op;
        logic [2:0]  pri;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue corner cases
        send_request(pack_request(OP_POP, 8'hFF, 3'd7));
        send_request(pack_request(OP_PEEK, 8'h00, 3'd0));
        send_request(pack_request(OP_UNUSED, 8'hFF, 3'd7));
        // fill to capacity: extremes, equal priorities in arrival order
        send_request(pack_request(OP_PUSH, 8'h00, 3'd0));
        send_request(pack_request(OP_PUSH, 8'hFF, 3'd7));
        send_request(pack_request(OP_PUSH, 8'hA5, 3'd7));
        send_request(pack_request(OP_PUSH, 8'h5A, 3'd0));
        send_request(pack_request(OP_PUSH, 8'h11, 3'd3));
        send_request(pack_request(OP_PUSH, 8'h22, 3'd3));
        send_request(pack_request(OP_PUSH, 8'h33, 3'd5));
        send_request(pack_request(OP_PUSH, 8'h44, 3'd1));
        send_request(pack_request(OP_PUSH, 8'h55, 3'd7));
        send_request(pack_request(OP_PUSH, 8'h66, 3'd3));
        send_request(pack_request(OP_PUSH, 8'h77, 3'd2));
        send_request(pack_request(OP_PUSH, 8'h88, 3'd6));
        send_request(pack_request(OP_PUSH, 8'h99, 3'd4));
        send_request(pack_request(OP_PUSH, 8'hAA, 3'd0));
        send_request(pack_request(OP_PUSH, 8'hBB, 3'd5));
        send_request(pack_request(OP_PUSH, 8'hCC, 3'd6));
        send_request(pack_request(OP_PUSH, 8'hF0, 3'd7));   // drops: full
        send_request(pack_request(OP_UNUSED, 8'h00, 3'd0));
        send_request(pack_request(OP_PEEK, 8'hFF, 3'd7));
        send_request(pack_request(OP_POP, 8'h00, 3'd0));
        send_request(pack_request(OP_POP, 8'h00, 3'd0));

        push_pct = 50;
        for (n = 0; n < 1500; n++) begin
            // alternate fill and drain phases so full and empty both recur
            if (n % 80 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 50;
                    default: push_pct = 20;
                endcase
            end
            if (n == 200)
                press_req = 1'b1;
            if (n == 600)
                idle_pct = 0;
            if (n == 900)
                idle_pct = 36;
            r = $urandom_range(99);
            if (r < push_pct) begin
                op = OP_PUSH;
            end else begin
                r = $urandom_range(9);
                op = (r < 6) ? OP_POP : (r < 9) ? OP_PEEK : OP_UNUSED;
            end
            // narrow priority range half the time to stress equal-priority order
            pri = $urandom_range(1) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 3));
            send_request(pack_request(op, 8'($urandom), pri));
        end
        s_tvalid <= 1'b0;
        // let the monitor note the last transfer before draining
        @(posedge aclk);

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("** stable_priority_ready_queue_core: PASSED **");
        else
            $display("** stable_priority_ready_queue_core: FAILED **");
        $finish;
    end
endmodule
